// ----- hw/rtl/fbfl_pkg.sv -----
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and codes of the fixed block free list allocator: the request
// and response words, operation and status codes, configuration indexes.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int ADDR_W      = 48;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_USE_W    = 11;
  localparam int BSIZE_W     = 17;
  localparam int ALIGN_W     = 13;
  localparam int NBLK_W      = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int MAX_BSIZE   = (1 << BSIZE_W) - 1;
  localparam int MAX_ALIGN   = 4096;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE_USED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ALIGN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS  = 2'd3;

  // register reset values
  localparam logic [ADDR_W-1:0]  RST_POOL_BASE   = '0;
  localparam logic [BSIZE_W-1:0] RST_BLOCK_SIZE  = 17'd64;
  localparam logic [ALIGN_W-1:0] RST_BLOCK_ALIGN = 13'd8;
  localparam logic [NBLK_W-1:0]  RST_NUM_BLOCKS  = 11'd1024;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] block_address;
  } req_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   granted_address;
    logic [STATUS_W-1:0] status;
    logic [IN_USE_W-1:0] blocks_in_use;
    logic                pool_exhausted;
  } rsp_word_t;

endpackage

// ----- hw/rtl/fbfl_stream_if.sv -----
// ----------------------------------------------------------------------------
// fbfl_stream_if
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface fbfl_stream_if #(
  parameter type word_t = logic
) ();

  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ----- hw/rtl/fixed_block_free_list_allocator_top.sv -----
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_top
// Pool of equal-size blocks managed as a LIFO free list of next-block indices
// held in a link memory; alloc pops the head, free pushes the block index.
//
//   channel  dir  word        handshake
//   req      in   req_word_t  valid/ready
//   rsp      out  rsp_word_t  valid/ready
//   cfg      in   index+data  cfg_we, no back-pressure
//
// one request at a time; alloc pops the head link, free first divides the
// offset by the stride (one quotient bit per cycle in the divider), init
// rewrites the link memory one entry a cycle. after reset and after every
// register write the same rewrite runs with req.ready low. a request is
// taken while the previous response still waits; its response then waits
// for the slot.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_top
  import fbfl_pkg::*;
#(
  parameter int MAX_BLOCKS    = 1024,
  parameter int POINTER_BYTES = 8,
  parameter int ADDRESS_BITS  = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  fbfl_stream_if.sink          req,
  fbfl_stream_if.source        rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  localparam int IW       = $clog2(MAX_BLOCKS);
  localparam int CW       = $clog2(MAX_BLOCKS + 1);
  localparam int STRIDE_W = $clog2(MAX_BSIZE + POINTER_BYTES + MAX_ALIGN);
  localparam int SPAN_W   = CW + STRIDE_W;
  localparam int PROD_W   = IW + STRIDE_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ((ADDR_W'(1) << ADDRESS_BITS) - ADDR_W'(1));

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_ALLOC,
    S_CHECK,
    S_DIV,
    S_PUT
  } state_t;

  state_t state;

  // configuration
  logic [ADDR_W-1:0]  pool_base;
  logic [BSIZE_W-1:0] block_size;
  logic [ALIGN_W-1:0] block_alignment;
  logic [NBLK_W-1:0]  num_blocks;

  // geometry
  logic [ALIGN_W-1:0]  align_low;
  logic [ALIGN_W-1:0]  align_eff;
  logic [STRIDE_W-1:0] align_ext;
  logic [STRIDE_W-1:0] stride_raw;
  logic [STRIDE_W-1:0] stride_next;
  logic [STRIDE_W-1:0] stride;
  logic [SPAN_W-1:0]   span;
  logic [CW-1:0]       n_eff;

  // list state
  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] sweep;
  logic [CW-1:0] sweep_inc;
  logic          sweep_rsp;
  logic          sweep_wr;

  // work registers
  logic [ADDR_W-1:0]   addr_hold;
  logic [PROD_W-1:0]   prod;
  logic [ADDR_W-1:0]   res_granted;
  logic [STATUS_W-1:0] res_status;

  // free path
  logic [ADDR_W:0]   off_full;
  logic [ADDR_W-1:0] span_ext;
  logic              out_of_pool;
  logic              div_start;
  logic              div_done;
  logic [IW-1:0]     div_q;

  // link memory
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_wdata;
  logic [IW-1:0] mem_rdata;

  // response
  logic      rsp_valid;
  logic      put_fire;
  rsp_word_t rsp_word;
  logic [31:0] count_ext;

  always_comb begin
    align_low   = block_alignment & (~block_alignment + ALIGN_W'(1));
    align_eff   = (align_low == '0) ? ALIGN_W'(1) : align_low;
    align_ext   = {{(STRIDE_W-ALIGN_W){1'b0}}, align_eff};
    stride_raw  = STRIDE_W'(block_size) + STRIDE_W'(POINTER_BYTES);
    stride_next = (stride_raw + align_ext - STRIDE_W'(1)) & ~(align_ext - STRIDE_W'(1));
    if (32'(num_blocks) > 32'(MAX_BLOCKS)) begin
      n_eff = CW'(MAX_BLOCKS);
    end else begin
      n_eff = CW'(num_blocks);
    end
  end

  always_comb begin
    off_full    = {1'b0, addr_hold} - {1'b0, pool_base};
    span_ext    = {{(ADDR_W-SPAN_W){1'b0}}, span};
    out_of_pool = off_full[ADDR_W] || (off_full[ADDR_W-1:0] >= span_ext);
    div_start   = (state == S_CHECK) && !out_of_pool && (count != '0);
  end

  always_comb begin
    sweep_inc = sweep + CW'(1);
    sweep_wr  = (state == S_SWEEP) && (sweep < n_eff);
    mem_we    = sweep_wr || ((state == S_DIV) && div_done);
    if (sweep_wr) begin
      mem_waddr = sweep[IW-1:0];
      mem_wdata = sweep_inc[IW-1:0];
    end else begin
      mem_waddr = div_q;
      mem_wdata = head;
    end
  end

  assign count_ext = 32'(count);
  assign put_fire  = (state == S_PUT) && (!rsp_valid || rsp.ready);
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_word;

  fbfl_link_mem #(
    .DEPTH  (MAX_BLOCKS),
    .DATA_W (IW)
  ) u_link_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (head),
    .rdata (mem_rdata)
  );

  fbfl_divider #(
    .DIVIDEND_W (SPAN_W),
    .DIVISOR_W  (STRIDE_W),
    .QUOT_W     (IW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (off_full[SPAN_W-1:0]),
    .divisor  (stride),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_SWEEP;
      pool_base       <= RST_POOL_BASE;
      block_size      <= RST_BLOCK_SIZE;
      block_alignment <= RST_BLOCK_ALIGN;
      num_blocks      <= RST_NUM_BLOCKS;
      head            <= '0;
      count           <= '0;
      sweep           <= '0;
      sweep_rsp       <= 1'b0;
      rsp_valid       <= 1'b0;
    end else begin
      stride <= stride_next;
      span   <= SPAN_W'(n_eff) * SPAN_W'(stride);

      if (put_fire && !cfg_we) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      if (cfg_we) begin
        // register write rebuilds the free list for the new geometry
        unique case (cfg_index)
          CFG_POOL_BASE:   pool_base       <= cfg_data;
          CFG_BLOCK_SIZE:  block_size      <= cfg_data[BSIZE_W-1:0];
          CFG_BLOCK_ALIGN: block_alignment <= cfg_data[ALIGN_W-1:0];
          CFG_NUM_BLOCKS:  num_blocks      <= cfg_data[NBLK_W-1:0];
          default:         pool_base       <= pool_base;
        endcase
        head      <= '0;
        count     <= '0;
        sweep     <= '0;
        sweep_rsp <= 1'b0;
        state     <= S_SWEEP;
      end else begin
        unique case (state)
          S_SWEEP: begin
            if (sweep_wr) begin
              sweep <= sweep_inc;
            end else begin
              sweep_rsp <= 1'b0;
              state     <= sweep_rsp ? S_PUT : S_IDLE;
            end
          end
          S_IDLE: begin
            if (req.valid) begin
              res_granted <= '0;
              unique case (req.data.operation)
                OP_ALLOC: begin
                  if (count >= n_eff) begin
                    res_status <= ST_EXHAUSTED;
                    state      <= S_PUT;
                  end else begin
                    res_status <= ST_OK;
                    prod       <= PROD_W'(head) * PROD_W'(stride);
                    state      <= S_ALLOC;
                  end
                end
                OP_FREE: begin
                  res_status <= ST_OK;
                  addr_hold  <= req.data.block_address;
                  state      <= S_CHECK;
                end
                OP_INIT: begin
                  res_status <= ST_OK;
                  head       <= '0;
                  count      <= '0;
                  sweep      <= '0;
                  sweep_rsp  <= 1'b1;
                  state      <= S_SWEEP;
                end
                default: begin
                  res_status <= ST_OK;
                  state      <= S_PUT;
                end
              endcase
            end
          end
          S_ALLOC: begin
            head        <= mem_rdata;
            count       <= count + CW'(1);
            res_granted <= (pool_base + {{(ADDR_W-PROD_W){1'b0}}, prod}) & ADDR_MASK;
            state       <= S_PUT;
          end
          S_CHECK: begin
            if (out_of_pool) begin
              res_status <= ST_RANGE;
              state      <= S_PUT;
            end else if (count == '0) begin
              res_status <= ST_NONE_USED;
              state      <= S_PUT;
            end else begin
              state <= S_DIV;
            end
          end
          S_DIV: begin
            if (div_done) begin
              head  <= div_q;
              count <= count - CW'(1);
              state <= S_PUT;
            end
          end
          S_PUT: begin
            if (put_fire) begin
              rsp_word.granted_address <= res_granted;
              rsp_word.status          <= res_status;
              rsp_word.blocks_in_use   <= count_ext[IN_USE_W-1:0];
              rsp_word.pool_exhausted  <= (count >= n_eff);
              state                    <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// ----- hw/rtl/fbfl_link_mem.sv -----
// ----------------------------------------------------------------------------
// fbfl_link_mem
// Next-free link memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbfl_link_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/fbfl_divider.sv -----
// ----------------------------------------------------------------------------
// fbfl_divider
// Restoring divider, one quotient bit per cycle, for offset to block index.
// ----------------------------------------------------------------------------
module fbfl_divider #(
  parameter int DIVIDEND_W = 27,
  parameter int DIVISOR_W  = 17,
  parameter int QUOT_W     = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [QUOT_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [DIVIDEND_W-1:0] rem;
  logic [DIVIDEND_W-1:0] dsh;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  fits;

  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= dividend;
        dsh      <= {{(DIVIDEND_W-DIVISOR_W){1'b0}}, divisor} << (QUOT_W - 1);
        quotient <= '0;
        cnt      <= CNT_W'(QUOT_W);
        busy     <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= rem - dsh;
        end
        quotient <= {quotient[QUOT_W-2:0], fits};
        dsh      <= dsh >> 1;
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fixed block free list allocator. Drives alloc,
// free, init and unused opcodes over valid/ready with random gaps and stalls,
// rewrites the pool geometry between phases and checks every response word
// against a free-list predictor that tracks the link memory and the counts.
// ----------------------------------------------------------------------------
module testbench;
  import fbfl_pkg::*;

  localparam int POOL_CAP   = 1024;
  localparam int LINK_BYTES = 8;
  localparam int STALL_LIMIT = 20000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  class pool_checker;
    logic [ADDR_W-1:0]  base;
    logic [BSIZE_W-1:0] bsize;
    logic [ALIGN_W-1:0] balign;
    logic [NBLK_W-1:0]  nblk;
    int link [POOL_CAP];
    int head;
    int in_use;
    rsp_word_t owed[$];
    int errors;

    function new();
      errors = 0;
      base   = RST_POOL_BASE;
      bsize  = RST_BLOCK_SIZE;
      balign = RST_BLOCK_ALIGN;
      nblk   = RST_NUM_BLOCKS;
      for (int i = 0; i < POOL_CAP; i++) link[i] = i + 1;
      rechain();
    endfunction

    function int pool_count();
      return (nblk > POOL_CAP) ? POOL_CAP : int'(nblk);
    endfunction

    function logic [63:0] stride_bytes();
      logic [ALIGN_W-1:0] low_bit;
      logic [63:0] a;
      logic [63:0] raw;
      low_bit = balign & (~balign + 1'b1);
      a = (low_bit == '0) ? 64'd1 : 64'(low_bit);
      raw = 64'(bsize) + 64'(LINK_BYTES);
      return (raw + a - 64'd1) & ~(a - 64'd1);
    endfunction

    function void rechain();
      int n;
      n = pool_count();
      for (int i = 0; i < n; i++) link[i] = i + 1;
      head = 0;
      in_use = 0;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
      case (idx)
        CFG_POOL_BASE:   base = val;
        CFG_BLOCK_SIZE:  bsize = val[BSIZE_W-1:0];
        CFG_BLOCK_ALIGN: balign = val[ALIGN_W-1:0];
        CFG_NUM_BLOCKS:  nblk = val[NBLK_W-1:0];
        default: ;
      endcase
      rechain();
    endfunction

    function rsp_word_t note_request(req_word_t w);
      rsp_word_t p;
      int n;
      int idx;
      logic [63:0] st;
      logic [63:0] off;
      logic [63:0] g;
      n  = pool_count();
      st = stride_bytes();
      p  = '0;
      p.status = ST_OK;
      case (w.operation)
        OP_ALLOC: begin
          if (in_use >= n) begin
            p.status = ST_EXHAUSTED;
          end else begin
            idx = head % POOL_CAP;
            g = {16'h0, base} + 64'(idx) * st;
            p.granted_address = g[ADDR_W-1:0];
            head = link[idx];
            in_use++;
          end
        end
        OP_FREE: begin
          off = {16'h0, w.block_address} - {16'h0, base};
          if (w.block_address < base || off >= 64'(n) * st) begin
            p.status = ST_RANGE;
          end else if (in_use == 0) begin
            p.status = ST_NONE_USED;
          end else begin
            idx = int'(off / st);
            if (idx >= POOL_CAP) idx = POOL_CAP - 1;
            link[idx] = head;
            head = idx;
            in_use--;
          end
        end
        OP_INIT: rechain();
        default: ;
      endcase
      p.blocks_in_use  = in_use[IN_USE_W-1:0];
      p.pool_exhausted = (in_use >= n);
      owed.push_back(p);
      return p;
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_response(rsp_word_t got);
      rsp_word_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected response %h", got));
        return;
      end
      want = owed.pop_front();
      if (got.granted_address !== want.granted_address)
        report($sformatf("granted_address %h, want %h", got.granted_address,
                         want.granted_address));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.blocks_in_use !== want.blocks_in_use)
        report($sformatf("blocks_in_use %0d, want %0d", got.blocks_in_use,
                         want.blocks_in_use));
      if (got.pool_exhausted !== want.pool_exhausted)
        report($sformatf("pool_exhausted %0d, want %0d", got.pool_exhausted,
                         want.pool_exhausted));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0] cfg_data;

  fbfl_stream_if #(.word_t(req_word_t)) req_bus ();
  fbfl_stream_if #(.word_t(rsp_word_t)) rsp_bus ();

  fixed_block_free_list_allocator_top #(
    .MAX_BLOCKS(POOL_CAP),
    .POINTER_BYTES(LINK_BYTES),
    .ADDRESS_BITS(ADDR_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  pool_checker sb;
  logic [ADDR_W-1:0] live[$];
  logic [ADDR_W-1:0] released[$];
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic req_word_t req_of(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a);
    req_word_t w;
    w.operation = op;
    w.block_address = a;
    return w;
  endfunction

  // call at a falling edge; returns at a falling edge
  task automatic send(req_word_t w);
    rsp_word_t p;
    while (!no_idle && $urandom_range(99) < 22) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.data <= w;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    p = sb.note_request(w);
    if (w.operation == OP_ALLOC && p.status == ST_OK) live.push_back(p.granted_address);
    if (w.operation == OP_INIT) begin
      live.delete();
      released.delete();
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // each write restarts the link memory rewrite; wait for the request side
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.configure(idx, val);
    live.delete();
    released.delete();
    repeat (2) @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_bus.ready <= 1'b0;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 300;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= no_idle || ($urandom_range(99) >= 22);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) sb.check_response(rsp_bus.data);
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int ph;
    int k;
    int j;
    int r;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] pbase;
    logic [BSIZE_W-1:0] psize;
    logic [ALIGN_W-1:0] palign;
    logic [NBLK_W-1:0] pcount;
    logic [63:0] st;
    logic [63:0] span;
    req_word_t w;

    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_POOL_BASE;
    cfg_data = '0;
    req_bus.valid = 1'b0;
    req_bus.data = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // reset geometry: stride 72, 1024 blocks
    send(req_of(OP_ALLOC, '1));
    send(req_of(OP_ALLOC, '0));
    send(req_of(OP_FREE, 48'd77));
    send(req_of(OP_FREE, 48'd0));
    send(req_of(OP_FREE, 48'd0));
    send(req_of(OP_FREE, 48'd73728));
    send(req_of(OP_FREE, 48'd73727));
    send(req_of(OP_FREE, '1));
    send(req_of(OP_ALLOC, '0));
    send(req_of(OP_ALLOC, '0));
    send(req_of(OP_ALLOC, '0));
    send(req_of(OP_FREE, 48'd72));
    send(req_of(OP_FREE, 48'd72));
    send(req_of(OP_ALLOC, '0));
    send(req_of(OP_ALLOC, '0));
    send(req_of(OP_UNUSED, '1));
    send(req_of(OP_INIT, '0));
    send(req_of(OP_ALLOC, '0));
    send(req_of(OP_FREE, 48'd143));
    wait_drained();

    for (ph = 0; ph < 11; ph++) begin
      pbase = 48'({$urandom, $urandom});
      psize = 17'($urandom_range(1, 256));
      palign = 13'(1 << $urandom_range(0, 12));
      pcount = 11'($urandom_range(1, 48));
      case (ph)
        0: begin
          pbase = 48'h1000; psize = 17'd1; palign = 13'd1; pcount = 11'd1;
        end
        1: begin
          psize = 17'd65536; palign = 13'd4096; pcount = 11'd2047;
        end
        2: begin
          pbase = 48'hFFFF_FFFF_FF38; psize = 17'd56; palign = 13'd64; pcount = 11'd8;
        end
        3: begin
          pbase = '1; psize = 17'd1; palign = 13'd1; pcount = 11'd4;
        end
        4: begin
          psize = 17'($urandom_range(0, 131071)); palign = '0; pcount = '0;
        end
        5: begin
          palign = 13'd8191; pcount = 11'($urandom_range(2, 12));
        end
        6: begin
          pbase = 48'h40; psize = 17'd24; palign = 13'd16; pcount = 11'd3;
        end
        7: begin
          psize = 17'd64; palign = 13'd8; pcount = 11'd1024;
        end
        8: begin
          palign = 13'($urandom_range(0, 8191)); pcount = 11'($urandom_range(1, 6));
        end
        9: begin
          psize = 17'($urandom_range(1, 65536)); pcount = 11'($urandom_range(1, 2047));
        end
        default: ;
      endcase
      write_reg(CFG_POOL_BASE, pbase);
      write_reg(CFG_BLOCK_SIZE, 48'(psize));
      write_reg(CFG_BLOCK_ALIGN, 48'(palign));
      write_reg(CFG_NUM_BLOCKS, 48'(pcount));
      no_idle = (ph == 6);
      if (ph == 1) hold_request = 1'b1;

      for (k = 0; k < 100; k++) begin
        if (ph == 8 && k == 50) wait_drained();
        st = sb.stride_bytes();
        span = 64'(sb.pool_count()) * st;
        r = $urandom_range(99);
        w.operation = OP_ALLOC;
        w.block_address = 48'({$urandom, $urandom});
        if (r >= 44 && r < 76 && live.size() > 0) begin
          j = $urandom_range(live.size() - 1);
          a = live[j];
          live.delete(j);
          released.push_back(a);
          if (released.size() > 16) void'(released.pop_front());
          if ($urandom_range(3) == 0) a = a + $urandom_range(32'(st - 1));
          w.operation = OP_FREE;
          w.block_address = a;
        end else if (r >= 76 && r < 84) begin
          w.operation = OP_FREE;
          case ($urandom_range(3))
            0: ;
            1: w.block_address = sb.base - 1'b1;
            2: w.block_address = sb.base + span[ADDR_W-1:0];
            default: w.block_address = sb.base + span[ADDR_W-1:0] - 1'b1;
          endcase
        end else if (r >= 84 && r < 88 && released.size() > 0) begin
          w.operation = OP_FREE;
          w.block_address = released[$urandom_range(released.size() - 1)];
        end else if (r >= 88 && r < 91) begin
          w.operation = OP_INIT;
        end else if (r >= 91 && r < 94) begin
          w.operation = OP_UNUSED;
        end
        send(w);
      end
      wait_drained();
    end

    no_idle = 1'b0;
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- fixed_block_free_list_allocator_top.f -----
hw/rtl/fbfl_pkg.sv
hw/rtl/fbfl_stream_if.sv
hw/rtl/fbfl_link_mem.sv
hw/rtl/fbfl_divider.sv
hw/rtl/fixed_block_free_list_allocator_top.sv
bench/testbench.sv
